@@ hdl/lruwb_pkg.sv @@
// Package for the LRU write-back page cache: payload structs, result kinds,
// register indexes and the sequencer state type. No dependencies.
package lruwb_pkg;

  localparam int BLK_W = 27;
  localparam int DEV_W = 8;
  localparam int SIZE_W = 16;
  localparam int DIRTY_OUT_W = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam int THR_W = 7;
  localparam int QUOTA_W = 16;
  localparam int ACC_W = 20;

  localparam logic [1:0] KIND_EVICT = 2'd0;
  localparam logic [1:0] KIND_FETCH = 2'd1;
  localparam logic [1:0] KIND_FLUSH = 2'd2;
  localparam logic [1:0] KIND_DONE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_DIRTY_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLUSH_QUOTA = 1'd1;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef struct packed {
    logic [BLK_W-1:0] block_number;
    logic access_type;
    logic [SIZE_W-1:0] size_sectors;
    logic [DEV_W-1:0] device;
  } request_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [BLK_W-1:0] out_block;
    logic [DEV_W-1:0] out_device;
    logic [SIZE_W-1:0] out_size;
    logic hit;
    logic [DIRTY_OUT_W-1:0] dirty_total;
    logic last;
  } result_t;

  typedef struct packed {
    logic [BLK_W-1:0] tag;
    logic [DEV_W-1:0] dev;
    logic [SIZE_W-1:0] size;
  } page_rec_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_HIT,
    ST_MISS,
    ST_EV_OUT,
    ST_INSTALL,
    ST_FL_CHK,
    ST_FL_STEP,
    ST_FL_OUT,
    ST_DONE
  } state_t;

endpackage

@@ hdl/lru_write_back_page_cache.sv @@
// Top level of the LRU write-back page cache with dirty-count flush.
// Depends on lruwb_pkg for payload structs, result kinds and state type.
//
// A request is taken when start is high and busy is low; busy then stays
// high until the done result. Lookup scans the recency list from MRU to LRU
// through the single page memory read port, one frame per cycle, with the
// read port registered. A miss goes through MISS and INSTALL, with EV_OUT
// between them for a dirty victim write-back. The flush walk visits one clean
// frame per cycle; a dirty page also passes through FL_OUT, since each page
// record comes from the same memory port. Results appear one per strobe
// cycle on result/result_valid and cannot be held off; the final one carries
// last.
module lru_write_back_page_cache #(
  parameter int FRAMES = 32,
  parameter int BLOCK_BITS = 27
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  lruwb_pkg::request_t req,
  output logic result_valid,
  output lruwb_pkg::result_t result,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [lruwb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lruwb_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam int MB = (BLOCK_BITS < lruwb_pkg::BLK_W) ? BLOCK_BITS : lruwb_pkg::BLK_W;
  localparam logic [lruwb_pkg::BLK_W-1:0] BLK_MASK =
    lruwb_pkg::BLK_W'((64'd1 << MB) - 64'd1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(FRAMES);

  lruwb_pkg::state_t state, state_next;

  lruwb_pkg::page_rec_t mem [FRAMES];
  lruwb_pkg::page_rec_t mem_q;
  logic rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic wr_en;

  logic [IDX_W-1:0] order [FRAMES];
  logic [FRAMES-1:0] dirty;
  logic [CNT_W-1:0] filled, dirty_pages;
  logic [lruwb_pkg::THR_W-1:0] dirty_threshold;
  logic [lruwb_pkg::QUOTA_W-1:0] flush_quota;

  lruwb_pkg::request_t rq;
  logic [lruwb_pkg::BLK_W-1:0] blk;
  logic [CNT_W-1:0] k, pos_q, r;
  logic pend;
  logic hit;
  logic [IDX_W-1:0] frm_q, slot;
  logic [lruwb_pkg::ACC_W-1:0] acc, acc_sum;

  // Combinational controls.
  logic emit;
  lruwb_pkg::result_t res_c;
  logic shift_en;
  logic [CNT_W-1:0] shift_pos;
  logic [IDX_W-1:0] shift_frame;
  logic set_dirty, clr_dirty, inc_dp, dec_dp, inc_filled;
  logic [IDX_W-1:0] dirty_idx;
  logic load_req, issue, tag_match;
  logic [IDX_W-1:0] vic;
  logic [IDX_W-1:0] cur_frame;

  assign cfg_ready = 1'b1;
  assign busy = (state != lruwb_pkg::ST_IDLE);
  assign blk = rq.block_number & BLK_MASK;
  assign vic = order[FRAMES-1];
  assign cur_frame = order[r[IDX_W-1:0]];
  assign tag_match = (mem_q.tag == blk);
  assign acc_sum = acc + lruwb_pkg::ACC_W'(mem_q.size >> 3);

  always_ff @(posedge clk) begin
    if (rst) begin
      dirty_threshold <= 7'd13;
      flush_quota <= 16'd1024;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lruwb_pkg::REG_DIRTY_THRESHOLD: dirty_threshold <= cfg_data[lruwb_pkg::THR_W-1:0];
        lruwb_pkg::REG_FLUSH_QUOTA: flush_quota <= cfg_data;
        default: ;
      endcase
    end
  end

  // Page record memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[slot] <= '{tag: blk, dev: rq.device, size: rq.size_sectors};
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_comb begin
    state_next = state;
    emit = 1'b0;
    res_c = '0;
    shift_en = 1'b0;
    shift_pos = '0;
    shift_frame = slot;
    set_dirty = 1'b0;
    clr_dirty = 1'b0;
    inc_dp = 1'b0;
    dec_dp = 1'b0;
    inc_filled = 1'b0;
    dirty_idx = slot;
    load_req = 1'b0;
    issue = 1'b0;
    rd_en = 1'b0;
    rd_addr = order[k[IDX_W-1:0]];
    wr_en = 1'b0;
    unique case (state)
      lruwb_pkg::ST_IDLE: begin
        if (start) begin
          load_req = 1'b1;
          state_next = lruwb_pkg::ST_LOOKUP;
        end
      end
      lruwb_pkg::ST_LOOKUP: begin
        // Stop issuing once a match is seen so pos_q and frm_q keep the hit.
        issue = (k < filled) && !(pend && tag_match);
        rd_en = issue;
        if (filled == '0) begin
          state_next = lruwb_pkg::ST_MISS;
        end else if (pend && tag_match) begin
          state_next = lruwb_pkg::ST_HIT;
        end else if (pend && pos_q == filled - CNT_W'(1)) begin
          state_next = lruwb_pkg::ST_MISS;
        end
      end
      lruwb_pkg::ST_HIT: begin
        shift_en = 1'b1;
        shift_pos = pos_q;
        shift_frame = frm_q;
        dirty_idx = frm_q;
        if (rq.access_type == lruwb_pkg::REQ_WRITE && !dirty[frm_q]) begin
          set_dirty = 1'b1;
          inc_dp = 1'b1;
        end
        state_next = lruwb_pkg::ST_FL_CHK;
      end
      lruwb_pkg::ST_MISS: begin
        rd_addr = vic;
        if (filled == FULL && dirty[vic]) begin
          rd_en = 1'b1;
          state_next = lruwb_pkg::ST_EV_OUT;
        end else begin
          state_next = lruwb_pkg::ST_INSTALL;
        end
      end
      lruwb_pkg::ST_EV_OUT: begin
        emit = 1'b1;
        res_c.kind = lruwb_pkg::KIND_EVICT;
        res_c.out_block = mem_q.tag;
        res_c.out_device = mem_q.dev;
        res_c.out_size = mem_q.size;
        clr_dirty = 1'b1;
        dec_dp = 1'b1;
        state_next = lruwb_pkg::ST_INSTALL;
      end
      lruwb_pkg::ST_INSTALL: begin
        wr_en = 1'b1;
        shift_en = 1'b1;
        shift_pos = CNT_W'(FRAMES - 1);
        inc_filled = (filled != FULL);
        if (rq.access_type == lruwb_pkg::REQ_WRITE) begin
          set_dirty = 1'b1;
          inc_dp = 1'b1;
        end else begin
          clr_dirty = 1'b1;
          emit = 1'b1;
          res_c.kind = lruwb_pkg::KIND_FETCH;
          res_c.out_block = blk;
          res_c.out_device = rq.device;
          res_c.out_size = rq.size_sectors;
        end
        state_next = lruwb_pkg::ST_FL_CHK;
      end
      lruwb_pkg::ST_FL_CHK: begin
        if (lruwb_pkg::THR_W'(dirty_pages) >= dirty_threshold && flush_quota != '0) begin
          state_next = lruwb_pkg::ST_FL_STEP;
        end else begin
          state_next = lruwb_pkg::ST_DONE;
        end
      end
      lruwb_pkg::ST_FL_STEP: begin
        rd_addr = cur_frame;
        if (dirty[cur_frame]) begin
          rd_en = 1'b1;
          state_next = lruwb_pkg::ST_FL_OUT;
        end else if (r == '0) begin
          state_next = lruwb_pkg::ST_DONE;
        end
      end
      lruwb_pkg::ST_FL_OUT: begin
        emit = 1'b1;
        res_c.kind = lruwb_pkg::KIND_FLUSH;
        res_c.out_block = mem_q.tag;
        res_c.out_device = mem_q.dev;
        res_c.out_size = mem_q.size;
        clr_dirty = 1'b1;
        dec_dp = 1'b1;
        dirty_idx = frm_q;
        if (r == '0 || acc_sum >= lruwb_pkg::ACC_W'(flush_quota)) begin
          state_next = lruwb_pkg::ST_DONE;
        end else begin
          state_next = lruwb_pkg::ST_FL_STEP;
        end
      end
      lruwb_pkg::ST_DONE: begin
        emit = 1'b1;
        res_c.kind = lruwb_pkg::KIND_DONE;
        res_c.hit = hit;
        res_c.dirty_total = lruwb_pkg::DIRTY_OUT_W'(dirty_pages);
        res_c.last = 1'b1;
        state_next = lruwb_pkg::ST_IDLE;
      end
      default: state_next = lruwb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lruwb_pkg::ST_IDLE;
      result_valid <= 1'b0;
      dirty <= '0;
      filled <= '0;
      dirty_pages <= '0;
      pend <= 1'b0;
    end else begin
      state <= state_next;
      result_valid <= emit;
      if (set_dirty) dirty[dirty_idx] <= 1'b1;
      else if (clr_dirty) dirty[dirty_idx] <= 1'b0;
      if (inc_dp) dirty_pages <= dirty_pages + CNT_W'(1);
      else if (dec_dp) dirty_pages <= dirty_pages - CNT_W'(1);
      if (inc_filled) filled <= filled + CNT_W'(1);
      pend <= issue;
    end
  end

  // Recency list: order[0] is the MRU frame. Moving a frame to the front
  // shifts every entry up to its old position back by one.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int j = 1; j < FRAMES; j++) begin
        if (CNT_W'(j) <= shift_pos) order[j] <= order[j-1];
      end
      order[0] <= shift_frame;
    end
  end

  always_ff @(posedge clk) begin
    result <= res_c;
    if (load_req) begin
      rq <= req;
      k <= '0;
      hit <= 1'b0;
    end
    if (issue) begin
      k <= k + CNT_W'(1);
      pos_q <= k;
      frm_q <= order[k[IDX_W-1:0]];
    end
    if (state == lruwb_pkg::ST_LOOKUP && state_next == lruwb_pkg::ST_HIT) begin
      hit <= 1'b1;
    end
    if (state == lruwb_pkg::ST_MISS) begin
      slot <= (filled == FULL) ? vic : filled[IDX_W-1:0];
    end
    if (state == lruwb_pkg::ST_FL_CHK) begin
      r <= filled - CNT_W'(1);
      acc <= '0;
    end
    if (state == lruwb_pkg::ST_FL_STEP) begin
      frm_q <= cur_frame;
      if (!dirty[cur_frame] && r != '0) r <= r - CNT_W'(1);
    end
    if (state == lruwb_pkg::ST_FL_OUT) begin
      acc <= acc_sum;
      if (r != '0) r <= r - CNT_W'(1);
    end
  end

  a_done_frees: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |-> !busy)
    else $error("done result while still busy");
  a_dirty_bound: assert property (@(posedge clk) disable iff (rst)
    dirty_pages <= filled)
    else $error("dirty count exceeds filled frames");
  a_filled_bound: assert property (@(posedge clk) disable iff (rst)
    filled <= FULL)
    else $error("filled count out of range");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted without going busy");

endmodule
